// ===== rtl/rlenc_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-length encoder package
// Limits, buffer geometry and the types passed between the encoder's parts.
// ----------------------------------------------------------------------------
package rlenc_pkg;

   localparam int LITERAL_LIMIT = 120;
   localparam int REPEAT_LIMIT  = 127;
   localparam int LIT_DEPTH     = LITERAL_LIMIT - 1;

   localparam int CHUNK_BYTES   = 8;
   localparam int LANE_W        = $clog2(CHUNK_BYTES);
   localparam int CHUNK_CNT_W   = 4;

   localparam int LEN_W         = 7;
   localparam int BUF_AW        = 8;
   localparam int BUF_DEPTH     = 1 << BUF_AW;
   localparam int FILL_W        = BUF_AW + 1;

   localparam logic [7:0] LIT_FLAG  = 8'h80;
   localparam logic [7:0] TERM_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LIT,
      MODE_REP
   } run_mode_type;

   typedef enum logic [2:0] {
      ACT_OPEN,
      ACT_APPEND,
      ACT_TO_REPEAT,
      ACT_LIT_SPLIT,
      ACT_REP_EXTEND,
      ACT_REP_BREAK
   } act_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LIT,
      OP_REP
   } op_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_A_HEAD,
      PH_A_BODY,
      PH_B_HEAD,
      PH_B_BODY,
      PH_TERM0,
      PH_TERM1
   } phase_type;

   // One run to send: a literal from the buffer, or a repeat count and byte
   typedef struct packed {
      op_kind_type        kind;
      logic [BUF_AW-1:0]  ptr;
      logic [LEN_W-1:0]   len;
      logic [7:0]         value;
   } op_type;

   typedef struct packed {
      op_type  op_a;
      op_type  op_b;
      logic    term;
   } cmd_type;

   typedef struct packed {
      logic               en;
      logic [BUF_AW-1:0]  addr;
      logic [7:0]         data;
   } buf_wr_type;

   typedef struct packed {
      logic [8*CHUNK_BYTES-1:0]  bytes;
      logic [CHUNK_CNT_W-1:0]    count;
      logic                      step_done;
      logic                      stream_done;
   } chunk_type;

endpackage

// ===== rtl/rlenc_fifo.sv =====
// ----------------------------------------------------------------------------
// Encoder queue
// Small first-in first-out queue of register entries, head shown combinationally.
// ----------------------------------------------------------------------------
module rlenc_fifo #(
   parameter type ENTRY_TYPE = logic,
   parameter int  DEPTH      = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  ENTRY_TYPE  push_data,
   input  logic       pop,
   output ENTRY_TYPE  head,
   output logic       empty,
   output logic       full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ENTRY_TYPE          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== rtl/rlenc_front.sv =====
// ----------------------------------------------------------------------------
// Encoder front end
// Classifies each byte against the open run and issues send commands.
// ----------------------------------------------------------------------------
module rlenc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_input,
   input  logic                  cmdq_full,
   input  logic                  buf_free,
   output logic                  full,
   output logic                  cmd_push,
   output rlenc_pkg::cmd_type    cmd,
   output rlenc_pkg::buf_wr_type buf_wr
);
   import rlenc_pkg::*;

   run_mode_type       mode_ff, mode_in;
   logic [LEN_W-1:0]   lit_len_ff, lit_len_in;
   logic [BUF_AW-1:0]  lit_start_ff, lit_start_in;
   logic [7:0]         lit_tail_ff, lit_tail_in;
   logic [7:0]         rep_value_ff, rep_value_in;
   logic [LEN_W-1:0]   rep_len_ff, rep_len_in;
   logic [BUF_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   logic     accept;
   act_type  action;
   logic     wr_en;
   logic     rewind;

   assign full   = cmdq_full || (fill_ff == FILL_W'(BUF_DEPTH));
   assign accept = req_push && !full;

   // classify the byte
   always_comb begin
      case (mode_ff)
         MODE_LIT: begin
            if (req_data_byte == lit_tail_ff) begin
               action = ACT_TO_REPEAT;
            end else if (lit_len_ff >= LEN_W'(LIT_DEPTH)) begin
               action = ACT_LIT_SPLIT;
            end else begin
               action = ACT_APPEND;
            end
         end
         MODE_REP: begin
            if (req_data_byte == rep_value_ff && rep_len_ff < LEN_W'(REPEAT_LIMIT)) begin
               action = ACT_REP_EXTEND;
            end else begin
               action = ACT_REP_BREAK;
            end
         end
         default: begin
            action = ACT_OPEN;
         end
      endcase
   end

   // the tail byte leaves the literal: take back its buffer slot
   assign rewind = accept && (action == ACT_TO_REPEAT);
   assign wr_en  = accept && (action != ACT_TO_REPEAT) && (action != ACT_REP_EXTEND);

   // run state
   always_comb begin
      mode_in      = mode_ff;
      lit_len_in   = lit_len_ff;
      lit_start_in = lit_start_ff;
      lit_tail_in  = lit_tail_ff;
      rep_value_in = rep_value_ff;
      rep_len_in   = rep_len_ff;
      wr_ptr_in    = wr_ptr_ff;
      if (accept) begin
         case (action)
            ACT_TO_REPEAT: begin
               mode_in      = MODE_REP;
               rep_value_in = req_data_byte;
               rep_len_in   = LEN_W'(2);
               lit_len_in   = '0;
               wr_ptr_in    = wr_ptr_ff - 1'b1;
            end
            ACT_APPEND: begin
               lit_len_in  = lit_len_ff + 1'b1;
               lit_tail_in = req_data_byte;
               wr_ptr_in   = wr_ptr_ff + 1'b1;
            end
            ACT_REP_EXTEND: begin
               rep_len_in = rep_len_ff + 1'b1;
            end
            default: begin
               mode_in      = MODE_LIT;
               lit_start_in = wr_ptr_ff;
               lit_len_in   = LEN_W'(1);
               lit_tail_in  = req_data_byte;
               wr_ptr_in    = wr_ptr_ff + 1'b1;
            end
         endcase
         if (req_end_of_input) begin
            mode_in    = MODE_NONE;
            lit_len_in = '0;
            rep_len_in = '0;
         end
      end
      fill_in = fill_ff + FILL_W'(wr_en) - FILL_W'(buf_free) - FILL_W'(rewind);
   end

   // send commands
   always_comb begin
      cmd = '0;
      case (action)
         ACT_TO_REPEAT: begin
            if (lit_len_ff > LEN_W'(1)) begin
               cmd.op_a.kind = OP_LIT;
               cmd.op_a.ptr  = lit_start_ff;
               cmd.op_a.len  = lit_len_ff - 1'b1;
            end
            cmd.op_b.kind  = OP_REP;
            cmd.op_b.len   = LEN_W'(2);
            cmd.op_b.value = req_data_byte;
         end
         ACT_APPEND: begin
            cmd.op_b.kind = OP_LIT;
            cmd.op_b.ptr  = lit_start_ff;
            cmd.op_b.len  = lit_len_ff + 1'b1;
         end
         ACT_LIT_SPLIT: begin
            cmd.op_a.kind = OP_LIT;
            cmd.op_a.ptr  = lit_start_ff;
            cmd.op_a.len  = lit_len_ff;
            cmd.op_b.kind = OP_LIT;
            cmd.op_b.ptr  = wr_ptr_ff;
            cmd.op_b.len  = LEN_W'(1);
         end
         ACT_REP_EXTEND: begin
            cmd.op_b.kind  = OP_REP;
            cmd.op_b.len   = rep_len_ff + 1'b1;
            cmd.op_b.value = rep_value_ff;
         end
         ACT_REP_BREAK: begin
            cmd.op_a.kind  = OP_REP;
            cmd.op_a.len   = rep_len_ff;
            cmd.op_a.value = rep_value_ff;
            cmd.op_b.kind  = OP_LIT;
            cmd.op_b.ptr   = wr_ptr_ff;
            cmd.op_b.len   = LEN_W'(1);
         end
         default: begin
            cmd.op_b.kind = OP_LIT;
            cmd.op_b.ptr  = wr_ptr_ff;
            cmd.op_b.len  = LEN_W'(1);
         end
      endcase
      // the closing run is sent only at end of stream
      if (!req_end_of_input) begin
         cmd.op_b = '0;
      end
      cmd.term = req_end_of_input;
   end

   assign cmd_push = accept && (cmd.op_a.kind != OP_NONE || req_end_of_input);

   assign buf_wr.en   = wr_en;
   assign buf_wr.addr = wr_ptr_ff;
   assign buf_wr.data = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NONE;
         lit_len_ff <= '0;
         rep_len_ff <= '0;
         wr_ptr_ff  <= '0;
         fill_ff    <= '0;
      end else begin
         mode_ff    <= mode_in;
         lit_len_ff <= lit_len_in;
         rep_len_ff <= rep_len_in;
         wr_ptr_ff  <= wr_ptr_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_start_ff <= lit_start_in;
      lit_tail_ff  <= lit_tail_in;
      rep_value_ff <= rep_value_in;
   end

endmodule

// ===== rtl/rlenc_back.sv =====
// ----------------------------------------------------------------------------
// Encoder back end
// Literal buffer; walks commands a byte a cycle unless chunk_full; packs chunks.
// ----------------------------------------------------------------------------
module rlenc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rlenc_pkg::cmd_type    cmdq_head,
   input  logic                  cmdq_empty,
   output logic                  cmdq_pop,
   input  rlenc_pkg::buf_wr_type buf_wr,
   output logic                  buf_free,
   output logic                  chunk_push,
   output rlenc_pkg::chunk_type  chunk,
   input  logic                  chunk_full
);
   import rlenc_pkg::*;

   logic [7:0]           lit_buf [BUF_DEPTH];
   logic [7:0]           rd_data_ff;

   phase_type            phase_ff, phase_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   cmd_type              cmd_ff;

   logic [8*CHUNK_BYTES-1:0]  acc_word_ff, acc_word_in;
   logic [LANE_W-1:0]         acc_cnt_ff, acc_cnt_in;

   op_type               op_cur;
   op_type               op_nxt;
   logic [LEN_W-1:0]     body_len;
   logic                 body_more;
   phase_type            after_a, after_b, first_phase;
   phase_type            seq_next;
   logic [LEN_W-1:0]     cnt_seq;
   logic                 byte_valid;
   logic [7:0]           byte_out;
   logic                 adv;
   logic                 cmd_end;
   logic                 load;
   logic                 rd_en;
   logic [BUF_AW-1:0]    rd_addr;
   logic [8*CHUNK_BYTES-1:0]  word;

   assign op_cur    = (phase_ff == PH_A_HEAD || phase_ff == PH_A_BODY) ? cmd_ff.op_a
                                                                       : cmd_ff.op_b;
   assign body_len  = (op_cur.kind == OP_LIT) ? op_cur.len : LEN_W'(1);
   assign body_more = ({1'b0, cnt_ff} + 1'b1) < {1'b0, body_len};

   assign after_b = cmd_ff.term ? PH_TERM0 : PH_IDLE;
   assign after_a = (cmd_ff.op_b.kind != OP_NONE) ? PH_B_HEAD : after_b;
   assign first_phase = (cmdq_head.op_a.kind != OP_NONE) ? PH_A_HEAD :
                        (cmdq_head.op_b.kind != OP_NONE) ? PH_B_HEAD : PH_TERM0;

   // next state
   always_comb begin
      seq_next = PH_IDLE;
      cnt_seq  = '0;
      case (phase_ff)
         PH_A_HEAD: seq_next = PH_A_BODY;
         PH_A_BODY: begin
            if (body_more) begin
               seq_next = PH_A_BODY;
               cnt_seq  = cnt_ff + 1'b1;
            end else begin
               seq_next = after_a;
            end
         end
         PH_B_HEAD: seq_next = PH_B_BODY;
         PH_B_BODY: begin
            if (body_more) begin
               seq_next = PH_B_BODY;
               cnt_seq  = cnt_ff + 1'b1;
            end else begin
               seq_next = after_b;
            end
         end
         PH_TERM0: seq_next = PH_TERM1;
         default:  seq_next = PH_IDLE;
      endcase

      cmd_end = adv && (seq_next == PH_IDLE);
      load    = ((phase_ff == PH_IDLE) || cmd_end) && !cmdq_empty;

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         phase_in = first_phase;
         cnt_in   = '0;
      end else if (adv) begin
         phase_in = seq_next;
         cnt_in   = cnt_seq;
      end
   end

   // byte on the walk and buffer read for the byte after it
   always_comb begin
      byte_valid = (phase_ff != PH_IDLE);
      case (phase_ff)
         PH_A_HEAD, PH_B_HEAD: begin
            byte_out = (op_cur.kind == OP_LIT) ? (LIT_FLAG | {1'b0, op_cur.len})
                                               : {1'b0, op_cur.len};
         end
         PH_A_BODY, PH_B_BODY: begin
            byte_out = (op_cur.kind == OP_LIT) ? rd_data_ff : op_cur.value;
         end
         PH_TERM0, PH_TERM1: byte_out = TERM_BYTE;
         default:            byte_out = '0;
      endcase
   end

   assign adv     = byte_valid && !chunk_full;
   assign op_nxt  = (seq_next == PH_A_BODY) ? cmd_ff.op_a : cmd_ff.op_b;
   assign rd_en   = adv && (seq_next == PH_A_BODY || seq_next == PH_B_BODY)
                    && (op_nxt.kind == OP_LIT);
   assign rd_addr = op_nxt.ptr + BUF_AW'(cnt_seq);

   assign cmdq_pop = load;
   assign buf_free = rd_en;

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         lit_buf[buf_wr.addr] <= buf_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= lit_buf[rd_addr];
      end
   end

   // chunk packing
   always_comb begin
      for (int i = 0; i < CHUNK_BYTES; i++) begin
         word[8*i +: 8] = acc_word_ff[8*i +: 8]
                          | ((acc_cnt_ff == LANE_W'(i)) ? byte_out : 8'h00);
      end
      chunk_push        = adv && ((acc_cnt_ff == LANE_W'(CHUNK_BYTES - 1)) || cmd_end);
      chunk.bytes       = word;
      chunk.count       = CHUNK_CNT_W'(acc_cnt_ff) + CHUNK_CNT_W'(1);
      chunk.step_done   = cmd_end;
      chunk.stream_done = cmd_end && cmd_ff.term;

      acc_word_in = acc_word_ff;
      acc_cnt_in  = acc_cnt_ff;
      if (chunk_push) begin
         acc_word_in = '0;
         acc_cnt_in  = '0;
      end else if (adv) begin
         acc_word_in = word;
         acc_cnt_in  = acc_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         cnt_ff      <= '0;
         acc_word_ff <= '0;
         acc_cnt_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         acc_word_ff <= acc_word_in;
         acc_cnt_ff  <= acc_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmdq_head;
      end
   end

endmodule

// ===== rtl/rle_literal_repeat_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Literal/repeat run-length encoder
// Throughput: one request a cycle while the literal buffer and command queue
//   have room; the back end sends one encoded byte a cycle while the result
//   queue has room.
// Reset: synchronous; empties both queues and closes any open run.
// ----------------------------------------------------------------------------
module rle_literal_repeat_encoder_unit #(
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_input,

   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [63:0]  rsp_chunk_bytes,
   output logic [3:0]   rsp_chunk_count,
   output logic         rsp_step_done,
   output logic         rsp_stream_done
);
   import rlenc_pkg::*;

   // Front to back: one command per request that sends anything. Literal
   // bytes themselves go straight into the ring buffer in the back end; the
   // command only carries where a literal starts and how long it is.
   logic        cmd_push;
   cmd_type     cmd;
   logic        cmdq_full;
   logic        cmdq_empty;
   logic        cmdq_pop;
   cmd_type     cmdq_head;

   buf_wr_type  buf_wr;
   logic        buf_free;

   // Back end to result queue
   logic        chunk_push;
   chunk_type   chunk;
   logic        chunk_full;
   chunk_type   rsp_head;

   // Front end: tracks the open run, writes literal bytes into the buffer
   // and stalls the request side when the buffer or command queue is full.
   rlenc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .cmdq_full        (cmdq_full),
      .buf_free         (buf_free),
      .full             (req_full),
      .cmd_push         (cmd_push),
      .cmd              (cmd),
      .buf_wr           (buf_wr)
   );

   // Short queue that lets the front keep taking bytes during a long flush
   rlenc_fifo #(
      .ENTRY_TYPE (cmd_type),
      .DEPTH      (CMD_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (cmdq_pop),
      .head      (cmdq_head),
      .empty     (cmdq_empty),
      .full      (cmdq_full)
   );

   // Back end: walks each command byte by byte and packs eight to a chunk
   rlenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_head  (cmdq_head),
      .cmdq_empty (cmdq_empty),
      .cmdq_pop   (cmdq_pop),
      .buf_wr     (buf_wr),
      .buf_free   (buf_free),
      .chunk_push (chunk_push),
      .chunk      (chunk),
      .chunk_full (chunk_full)
   );

   // Result queue: holds finished chunks so the back end keeps going while
   // the consumer holds off popping
   rlenc_fifo #(
      .ENTRY_TYPE (chunk_type),
      .DEPTH      (RSP_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (chunk_push),
      .push_data (chunk),
      .pop       (rsp_pop && !rsp_empty),
      .head      (rsp_head),
      .empty     (rsp_empty),
      .full      (chunk_full)
   );

   assign rsp_chunk_bytes = rsp_head.bytes;
   assign rsp_chunk_count = rsp_head.count;
   assign rsp_step_done   = rsp_head.step_done;
   assign rsp_stream_done = rsp_head.stream_done;

   // The front only issues a command when the queue has room
   a_cmdq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmdq_full)
      else $error("command pushed into a full queue");

   // The back end holds its byte while the result queue is full
   a_rspq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      chunk_push |-> !chunk_full)
      else $error("chunk pushed into a full result queue");

   // A stream ends only on the last chunk of its request
   a_stream_ends_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_stream_done) |-> rsp_step_done)
      else $error("stream done without step done");

   // Every chunk shown carries one to eight bytes
   a_chunk_nonempty: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_chunk_count != 4'd0 && rsp_chunk_count <= 4'd8))
      else $error("chunk byte count out of range");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the literal/repeat run-length encoder
// Feeds byte streams through the request port and checks every chunk that
// comes out against a cycle-free encoder written alongside, or against the
// table for typed rows. Directed streams go first (lone bytes, literal cut
// by a pair, repeat break, alternating bytes), then random runs of equal
// and distinct bytes, random idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rlenc_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_ITEMS   = 128;
   localparam int HOLD_AT        = 12;    // results taken before the long stall
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   // One line of the directed table: reps bytes starting at first_byte, each
   // stride above the one before. The end flag and any typed expectation
   // apply to the final byte of the line only.
   typedef struct {
      logic [7:0]  first_byte;
      logic [7:0]  stride;
      int          reps;
      logic        last;
      logic        typed;
      logic [63:0] exp_bytes;
      logic [3:0]  exp_count;
   } stim_row_type;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_push         = 1'b0;
   logic         req_full;
   logic [7:0]   req_data_byte    = '0;
   logic         req_end_of_input = 1'b0;
   logic         rsp_empty;
   logic         rsp_pop          = 1'b0;
   logic [63:0]  rsp_chunk_bytes;
   logic [3:0]   rsp_chunk_count;
   logic         rsp_step_done;
   logic         rsp_stream_done;

   // Encoder state as the block should hold it
   run_mode_type     run_mode = MODE_NONE;
   logic [7:0]       lit_store [LIT_DEPTH];
   logic [LEN_W-1:0] lit_len   = '0;
   logic [7:0]       rep_value = '0;
   logic [LEN_W-1:0] rep_len   = '0;

   logic [7:0]   coded_bytes[$];      // bytes produced by the current request
   chunk_type    step_chunks[$];      // the same, packed into chunks
   chunk_type    awaited_chunks[$];   // chunks the block still owes us
   stim_row_type directed_rows[$];

   int  mismatches  = 0;
   int  idle_cycles = 0;
   bit  sender_calm = 1'b0;
   bit  receiver_calm = 1'b0;

   rle_literal_repeat_encoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_chunk_bytes  (rsp_chunk_bytes),
      .rsp_chunk_count  (rsp_chunk_count),
      .rsp_step_done    (rsp_step_done),
      .rsp_stream_done  (rsp_stream_done)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Encoder prediction
   // ------------------------------------------------------------------------

   // Header with the run length, then the buffered bytes
   function automatic void emit_literal(int n);
      coded_bytes.push_back(LIT_FLAG | 8'(n));
      for (int i = 0; i < n; i++)
         coded_bytes.push_back(lit_store[i]);
   endfunction

   function automatic void emit_repeat();
      coded_bytes.push_back({1'b0, rep_len});
      coded_bytes.push_back(rep_value);
   endfunction

   function automatic void open_literal(logic [7:0] b);
      lit_store[0] = b;
      lit_len      = LEN_W'(1);
      run_mode     = MODE_LIT;
   endfunction

   // Advance the encoder by one byte and leave its output in step_chunks
   function automatic void encode_byte(logic [7:0] b, logic last);
      chunk_type c;
      int        pos;
      int        n;
      coded_bytes.delete();
      step_chunks.delete();

      case (run_mode)
         MODE_LIT: begin
            if (b == lit_store[lit_len - 1]) begin
               // the earlier of the equal pair leaves the literal
               if (lit_len > 1)
                  emit_literal(lit_len - 1);
               lit_len   = '0;
               rep_value = b;
               rep_len   = LEN_W'(2);
               run_mode  = MODE_REP;
            end else if (lit_len >= LIT_DEPTH) begin
               emit_literal(lit_len);
               open_literal(b);
            end else begin
               lit_store[lit_len] = b;
               lit_len = lit_len + 1'b1;
            end
         end
         MODE_REP: begin
            if (b == rep_value && rep_len < REPEAT_LIMIT) begin
               rep_len = rep_len + 1'b1;
            end else begin
               emit_repeat();
               open_literal(b);
            end
         end
         default: begin
            open_literal(b);
         end
      endcase

      // End of stream: flush whatever is open and append the terminator
      if (last) begin
         if (run_mode == MODE_LIT)
            emit_literal(lit_len);
         else if (run_mode == MODE_REP)
            emit_repeat();
         coded_bytes.push_back(TERM_BYTE);
         coded_bytes.push_back(TERM_BYTE);
         run_mode = MODE_NONE;
         lit_len  = '0;
         rep_len  = '0;
      end

      pos = 0;
      while (pos < coded_bytes.size()) begin
         n = coded_bytes.size() - pos;
         if (n > CHUNK_BYTES)
            n = CHUNK_BYTES;
         c = '0;
         for (int i = 0; i < n; i++)
            c.bytes[8*i +: 8] = coded_bytes[pos + i];
         c.count       = CHUNK_CNT_W'(n);
         c.step_done   = (pos + n >= coded_bytes.size());
         c.stream_done = last && c.step_done;
         step_chunks.push_back(c);
         pos += n;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one byte, hold it until the block takes it, then record what the
   // block owes for it. A typed row replaces the prediction with the value
   // written in the table.
   task automatic offer_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [63:0] exp_bytes, input logic [3:0] exp_count);
      int        gap;
      chunk_type c;
      gap = sender_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= last;
      do @(posedge clock); while (req_full);

      encode_byte(b, last);
      if (typed) begin
         if (exp_count != 0) begin
            c.bytes       = exp_bytes;
            c.count       = exp_count;
            c.step_done   = 1'b1;
            c.stream_done = last;
            awaited_chunks.push_back(c);
         end
      end else begin
         foreach (step_chunks[i])
            awaited_chunks.push_back(step_chunks[i]);
      end

      // switch between bursts with no idling and idling ones now and then
      if ($urandom_range(0, 15) == 0)
         sender_calm = !sender_calm;
   endtask

   function automatic void add_row(logic [7:0] first_byte, logic [7:0] stride, int reps,
                                   logic last, logic typed, logic [63:0] exp_bytes,
                                   logic [3:0] exp_count);
      stim_row_type r;
      r.first_byte = first_byte;
      r.stride     = stride;
      r.reps       = reps;
      r.last       = last;
      r.typed      = typed;
      r.exp_bytes  = exp_bytes;
      r.exp_count  = exp_count;
      directed_rows.push_back(r);
   endfunction

   initial begin : stimulus
      logic [7:0] b;
      logic [7:0] prev_byte;
      logic       last;
      int         random_items;
      int         kind;
      int         span;

      // first  stride reps last typed expected                count
      add_row(8'h00, 8'h00,   1, 1'b1, 1'b1, 64'h0000_0000_FFFF_0081, 4'd4); // lone zero
      add_row(8'hFF, 8'h00,   1, 1'b1, 1'b1, 64'h0000_0000_FFFF_FF81, 4'd4); // lone 0xFF
      add_row(8'h00, 8'h00,   2, 1'b0, 1'b1, 64'h0,                   4'd0); // run opens
      add_row(8'h00, 8'h00,   1, 1'b1, 1'b1, 64'h0000_0000_FFFF_0003, 4'd4); // repeat of 3
      add_row(8'h12, 8'h00,   1, 1'b0, 1'b1, 64'h0,                   4'd0);
      add_row(8'h34, 8'h00,   2, 1'b0, 1'b1, 64'h0000_0000_0000_1281, 4'd2); // literal cut by a pair
      add_row(8'h56, 8'h00,   1, 1'b1, 1'b1, 64'h0000_FFFF_5681_3402, 4'd6); // repeat break
      add_row(8'h00, 8'h80,  10, 1'b0, 1'b0, 64'h0,                   4'd0); // alternating
      add_row(8'h80, 8'h00,   3, 1'b1, 1'b0, 64'h0,                   4'd0);

      // Hold reset, then release it on a clock edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         b = directed_rows[r].first_byte;
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            last = (k == directed_rows[r].reps - 1);
            offer_byte(b, directed_rows[r].last && last, directed_rows[r].typed && last,
                       directed_rows[r].exp_bytes, directed_rows[r].exp_count);
            b = b + directed_rows[r].stride;
         end
      end

      // Random streams: runs of equal bytes, runs of distinct bytes and plain
      // noise, mostly short, now and then long enough to fill a run.
      prev_byte    = 8'h80;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 2);
         span = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 130)
                                             : $urandom_range(1, 8);
         if (kind == 0 && $urandom_range(0, 1) == 1)
            prev_byte = 8'($urandom);
         for (int k = 0; k < span && random_items < RANDOM_ITEMS; k++) begin
            case (kind)
               0:       b = prev_byte;
               1:       b = prev_byte + 8'($urandom_range(1, 255));
               default: b = 8'($urandom);
            endcase
            random_items++;
            // close the final stream so that nothing is left open
            last = (random_items == RANDOM_ITEMS) || ($urandom_range(0, 11) == 0);
            offer_byte(b, last, 1'b0, 64'h0, 4'd0);
            prev_byte = b;
         end
      end
      req_push <= 1'b0;

      // Drain: wait for every chunk owed, then give the block time to show
      // anything it should not send.
      while (awaited_chunks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   function automatic void flag(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endfunction

   // Compare the chunk taken at this edge with the oldest one owed
   function automatic void check_chunk();
      chunk_type want;
      if (awaited_chunks.size() == 0) begin
         mismatches++;
         $display("%0t: chunk expected none actual %h count %0d", $time,
                  rsp_chunk_bytes, rsp_chunk_count);
         return;
      end
      want = awaited_chunks.pop_front();
      if (rsp_chunk_bytes !== want.bytes)
         flag("chunk_bytes", want.bytes, rsp_chunk_bytes);
      if (rsp_chunk_count !== want.count)
         flag("chunk_count", 64'(want.count), 64'(rsp_chunk_count));
      if (rsp_step_done !== want.step_done)
         flag("step_done", 64'(want.step_done), 64'(rsp_step_done));
      if (rsp_stream_done !== want.stream_done)
         flag("stream_done", 64'(want.stream_done), 64'(rsp_stream_done));
   endfunction

   // Pop results with random gaps; once, hold off for a long stretch so that
   // the block backs up and refuses requests.
   initial begin : drain
      int gap;
      int taken;
      taken = 0;
      while (reset)
         @(posedge clock);
      forever begin
         gap = receiver_calm ? 0 : $urandom_range(0, 5);
         if (taken == HOLD_AT)
            gap += HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_chunk();
         taken++;
         if ($urandom_range(0, 15) == 0)
            receiver_calm = !receiver_calm;
      end
   end

   // Watchdog: end the run if neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== rle_literal_repeat_encoder_unit.f =====
rtl/rlenc_pkg.sv
rtl/rlenc_fifo.sv
rtl/rlenc_front.sv
rtl/rlenc_back.sv
rtl/rle_literal_repeat_encoder_unit.sv
tb/tb_top.sv
